// File: design/variable_resolution_stretch_top_macros.svh
// Assertion macros for the variable resolution stretch block.
// Used by the port checker; needs clk and rst_n in scope.
`ifndef VARIABLE_RESOLUTION_STRETCH_TOP_MACROS_SVH
`define VARIABLE_RESOLUTION_STRETCH_TOP_MACROS_SVH

// same-cycle implication
`define VRS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define VRS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: design/vrs_pkg.sv
// Shared types and constants of the variable resolution stretch block.
// No dependencies.
package vrs_pkg;

    localparam int FRAC_BITS      = 20;
    localparam int MAX_HALF_COUNT = 1023;
    localparam int QDEPTH         = 2;
    localparam int QPTR_W         = $clog2(QDEPTH);
    localparam int QCNT_W         = $clog2(QDEPTH + 1);

    localparam logic [31:0] R_ONE  = 32'h4000_0000;
    localparam logic [63:0] R_HALF = 64'h2000_0000;
    localparam logic signed [63:0] LIM      = 64'sh4000_0000_0000_0000;
    localparam logic signed [63:0] WRAP_LO  = 64'(180) << FRAC_BITS;
    localparam logic signed [63:0] WRAP_ADD = 64'(360) << FRAC_BITS;
    localparam logic signed [63:0] OUT_MAX  = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [63:0] OUT_MIN  = -64'sh0000_0000_8000_0000;
    localparam logic [63:0] FRAC_HALF = 64'(1) << (FRAC_BITS - 1);
    localparam logic [30:0] SPACING_ONE = 31'(1) << FRAC_BITS;

    typedef enum logic [2:0] {
        REG_START_LON = 3'd0,
        REG_END_LON   = 3'd1,
        REG_START_LAT = 3'd2,
        REG_END_LAT   = 3'd3,
        REG_INNER_SP  = 3'd4,
        REG_OUTER_SP  = 3'd5,
        REG_RATIO     = 3'd6,
        REG_HALF_CNT  = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic signed [31:0] inner_start_lon;
        logic signed [31:0] inner_end_lon;
        logic signed [31:0] inner_start_lat;
        logic signed [31:0] inner_end_lat;
        logic [30:0]        inner_spacing;
        logic [30:0]        outer_spacing;
        logic [31:0]        stretch_ratio;
        logic [9:0]         half_stretched_count;
    } cfg_t;

    typedef struct packed {
        logic signed [31:0] coord;
        logic               lon;
        logic               bypass;
        logic signed [31:0] start;
        logic [31:0]        span;
    } job_t;

    function automatic logic signed [63:0] clamp62(input logic signed [63:0] x);
        logic signed [63:0] y;
        y = x;
        if (x > LIM)
            y = LIM;
        else if (x < -LIM)
            y = -LIM;
        return y;
    endfunction

endpackage

// File: design/vrs_front.sv
// Front part: classifies an incoming coordinate and builds a queue job.
// Depends on vrs_pkg.
module vrs_front
    import vrs_pkg::*;
(
    input  cfg_t               cfg,
    input  logic signed [31:0] coordinate,
    input  logic               is_longitude,
    output job_t               job
);

    logic signed [31:0] start;
    logic signed [31:0] stop;
    logic signed [32:0] span_w;
    logic               in_box;

    always_comb
    begin
        start  = is_longitude ? cfg.inner_start_lon : cfg.inner_start_lat;
        stop   = is_longitude ? cfg.inner_end_lon : cfg.inner_end_lat;
        in_box = (coordinate >= start) && (coordinate <= stop);
        if (coordinate < start)
            span_w = 33'(start) - 33'(coordinate);
        else
            span_w = 33'(coordinate) - 33'(stop);
        job.coord  = coordinate;
        job.lon    = is_longitude;
        job.bypass = (cfg.stretch_ratio == R_ONE) || in_box;
        job.start  = start;
        job.span   = span_w[31:0];
    end

endmodule

// File: design/vrs_queue.sv
// Short job queue between front and back parts.
// Depends on vrs_pkg.
module vrs_queue
    import vrs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output logic nonempty,
    output job_t head
);

    job_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_reg, wr_next;
    logic [QPTR_W-1:0] rd_reg, rd_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              do_push;
    logic              do_pop;

    assign full     = (cnt_reg == QCNT_W'(QDEPTH));
    assign nonempty = (cnt_reg != '0);
    assign head     = mem_reg[rd_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && nonempty;

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (do_push)
            wr_next = (wr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_reg + 1'b1;
        if (do_pop)
            rd_next = (rd_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_reg + 1'b1;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_reg] <= push_job;
    end

endmodule

// File: design/vrs_back.sv
// Back part: divider, power loop, remainder and rim terms, output register.
// Depends on vrs_pkg.
module vrs_back
    import vrs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  logic               q_nonempty,
    input  job_t               q_head,
    output logic               q_pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] stretched_coordinate
);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_DIV  = 8'b0000_0010,
        S_LOOP = 8'b0000_0100,
        S_MUL  = 8'b0000_1000,
        S_ADDR = 8'b0001_0000,
        S_TOT  = 8'b0010_0000,
        S_RIM  = 8'b0100_0000,
        S_OUT  = 8'b1000_0000
    } state_t;

    function automatic logic [31:0] mulr(input logic [31:0] x, input logic [31:0] r);
        logic [63:0] s;
        s = 64'(x) * 64'(r) + R_HALF;
        return (s[63:62] != 2'b00) ? 32'hFFFF_FFFF : s[61:30];
    endfunction

    function automatic logic [31:0] emit(input logic signed [63:0] p, input logic lon);
        logic signed [63:0] q;
        q = p;
        if (lon && (p < WRAP_LO))
            q = clamp62(p + WRAP_ADD);
        if (q > OUT_MAX)
            q = OUT_MAX;
        else if (q < OUT_MIN)
            q = OUT_MIN;
        return q[31:0];
    endfunction

    state_t             state_reg;
    job_t               job_reg;
    logic [31:0]        quo_reg;
    logic [30:0]        rem_reg;
    logic [4:0]         cnt_reg;
    logic [31:0]        d_reg;
    logic [31:0]        g_reg;
    logic signed [44:0] acc_reg;
    logic [9:0]         it_reg;
    logic signed [63:0] p_reg;
    logic [63:0]        prod_reg;
    logic [62:0]        rim_prod_reg;
    logic [61:0]        fr_prod_reg;
    logic signed [63:0] tot_reg;
    logic               out_valid_reg;
    logic [31:0]        out_data_reg;

    logic [30:0]        di;
    logic [30:0]        dout;
    logic [9:0]         hc;
    logic               rim;
    logic [9:0]         n_st;
    logic [30:0]        p_rem;
    logic [30:0]        rim_frac;
    logic [31:0]        n_rim;
    logic signed [31:0] diff;
    logic [30:0]        mag;
    logic [31:0]        div_try;
    logic               div_ge;
    logic [31:0]        d_mul;
    logic signed [63:0] start_ext;
    logic signed [63:0] coord_ext;
    logic signed [63:0] acc_ext;
    logic [33:0]        grown;
    logic signed [63:0] addr;
    logic signed [63:0] sum_s;
    logic signed [63:0] fmag_s;
    logic [63:0]        fr_round;
    logic               out_free;

    always_comb
    begin
        di        = (cfg.inner_spacing == '0) ? 31'd1 : cfg.inner_spacing;
        dout      = (cfg.outer_spacing == '0) ? 31'd1 : cfg.outer_spacing;
        hc        = (cfg.half_stretched_count > 10'(MAX_HALF_COUNT))
                    ? 10'(MAX_HALF_COUNT) : cfg.half_stretched_count;
        rim       = quo_reg > 32'(hc);
        n_st      = rim ? hc : quo_reg[9:0];
        p_rem     = rim ? '0 : rem_reg;
        rim_frac  = rim ? rem_reg : '0;
        n_rim     = quo_reg - 32'(hc);
        diff      = $signed({1'b0, dout}) - $signed({1'b0, di});
        mag       = diff[31] ? 31'(-diff) : diff[30:0];
        div_try   = {rem_reg, quo_reg[31]};
        div_ge    = div_try >= {1'b0, di};
        d_mul     = mulr(d_reg, cfg.stretch_ratio);
        start_ext = 64'(job_reg.start);
        coord_ext = 64'(job_reg.coord);
        acc_ext   = 64'(acc_reg);
        grown     = 34'((prod_reg + R_HALF) >> 30);
        addr      = $signed({30'd0, grown}) - $signed({33'd0, p_rem});
        sum_s     = (rim_prod_reg > 63'(LIM)) ? LIM : $signed({1'b0, rim_prod_reg});
        fr_round  = 64'(fr_prod_reg) + FRAC_HALF;
        fmag_s    = $signed(fr_round >> FRAC_BITS);
        out_free  = !out_valid_reg || out_ready;
        q_pop     = (state_reg == S_IDLE) && q_nonempty;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (q_nonempty)
                        state_reg <= q_head.bypass ? S_OUT : S_DIV;
                end
                S_DIV:
                begin
                    if (cnt_reg == 5'd31)
                        state_reg <= S_LOOP;
                end
                S_LOOP:
                begin
                    if (it_reg == n_st)
                        state_reg <= S_MUL;
                end
                S_MUL:
                    state_reg <= S_ADDR;
                S_ADDR:
                    state_reg <= rim ? S_TOT : S_OUT;
                S_TOT:
                    state_reg <= S_RIM;
                S_RIM:
                    state_reg <= S_OUT;
                S_OUT:
                begin
                    if (out_free)
                        state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
            if ((state_reg == S_OUT) && out_free)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                job_reg <= q_head;
                p_reg   <= 64'(q_head.coord);
                quo_reg <= q_head.span;
                rem_reg <= '0;
                cnt_reg <= '0;
            end
            S_DIV:
            begin
                rem_reg <= div_ge ? 31'(div_try - {1'b0, di}) : div_try[30:0];
                quo_reg <= {quo_reg[30:0], div_ge};
                cnt_reg <= cnt_reg + 1'b1;
                d_reg   <= {1'b0, di};
                g_reg   <= R_ONE;
                acc_reg <= '0;
                it_reg  <= '0;
            end
            S_LOOP:
            begin
                g_reg <= mulr(g_reg, cfg.stretch_ratio);
                if (it_reg != n_st)
                begin
                    d_reg   <= d_mul;
                    acc_reg <= acc_reg + $signed({13'd0, d_mul}) - $signed({14'd0, di});
                    it_reg  <= it_reg + 1'b1;
                end
            end
            S_MUL:
            begin
                p_reg        <= (coord_ext > start_ext) ? coord_ext + acc_ext
                                                        : coord_ext - acc_ext;
                prod_reg     <= 64'(p_rem) * 64'(g_reg);
                rim_prod_reg <= 63'(n_rim) * 63'(mag);
                fr_prod_reg  <= 62'(rim_frac) * 62'(mag);
            end
            S_ADDR:
                p_reg <= (p_reg > start_ext) ? p_reg + addr : p_reg - addr;
            S_TOT:
                tot_reg <= diff[31] ? clamp62(-sum_s - fmag_s) : clamp62(sum_s + fmag_s);
            S_RIM:
                p_reg <= (p_reg > start_ext) ? clamp62(p_reg + tot_reg)
                                             : clamp62(p_reg - tot_reg);
            S_OUT:
            begin
                if (out_free)
                    out_data_reg <= emit(p_reg, job_reg.lon);
            end
            default:
                p_reg <= p_reg;
        endcase
    end

    assign out_valid            = out_valid_reg;
    assign stretched_coordinate = $signed(out_data_reg);

endmodule

// File: design/variable_resolution_stretch_top.sv
// Uniform or inner-box items go from the queue straight to the output state;
// others take the divider path, H' the stretched interval count (at most 1023):
// a 32-step restoring divider, then the power loop of H'+1 ratio multiplies.
// One item at a time in the back part, held by output stalls; a 2-entry queue holds arrivals.
// Reset: asynchronous active low; config registers return to defaults, queue and output empty.
// Top level: configuration registers, front, queue and back. Depends on vrs_pkg, vrs_front, vrs_queue and vrs_back.
module variable_resolution_stretch_top
    import vrs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] coordinate,
    input  logic               is_longitude,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] stretched_coordinate,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    cfg_t cfg_reg;
    job_t front_job;
    job_t q_head;
    logic q_full;
    logic q_nonempty;
    logic q_pop;

    assign cfg_ready = 1'b1;
    assign in_ready  = !q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.inner_start_lon      <= '0;
            cfg_reg.inner_end_lon        <= '0;
            cfg_reg.inner_start_lat      <= '0;
            cfg_reg.inner_end_lat        <= '0;
            cfg_reg.inner_spacing        <= SPACING_ONE;
            cfg_reg.outer_spacing        <= SPACING_ONE;
            cfg_reg.stretch_ratio        <= R_ONE;
            cfg_reg.half_stretched_count <= '0;
        end
        else if (cfg_valid)
        begin
            case (reg_idx_t'(cfg_index))
                REG_START_LON: cfg_reg.inner_start_lon      <= $signed(cfg_data);
                REG_END_LON:   cfg_reg.inner_end_lon        <= $signed(cfg_data);
                REG_START_LAT: cfg_reg.inner_start_lat      <= $signed(cfg_data);
                REG_END_LAT:   cfg_reg.inner_end_lat        <= $signed(cfg_data);
                REG_INNER_SP:  cfg_reg.inner_spacing        <= cfg_data[30:0];
                REG_OUTER_SP:  cfg_reg.outer_spacing        <= cfg_data[30:0];
                REG_RATIO:     cfg_reg.stretch_ratio        <= cfg_data;
                REG_HALF_CNT:  cfg_reg.half_stretched_count <= cfg_data[9:0];
                default:       cfg_reg <= cfg_reg;
            endcase
        end
    end

    vrs_front u_front (
        .cfg          (cfg_reg),
        .coordinate   (coordinate),
        .is_longitude (is_longitude),
        .job          (front_job)
    );

    vrs_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (in_valid),
        .push_job (front_job),
        .full     (q_full),
        .pop      (q_pop),
        .nonempty (q_nonempty),
        .head     (q_head)
    );

    vrs_back u_back (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cfg                  (cfg_reg),
        .q_nonempty           (q_nonempty),
        .q_head               (q_head),
        .q_pop                (q_pop),
        .out_valid            (out_valid),
        .out_ready            (out_ready),
        .stretched_coordinate (stretched_coordinate)
    );

endmodule

// File: design/vrs_checker.sv
// Port-level checker for the variable resolution stretch top, bound to it below.
// Depends on variable_resolution_stretch_top_macros.svh.
`include "variable_resolution_stretch_top_macros.svh"

module vrs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [31:0] coordinate,
    input logic        is_longitude,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] stretched_coordinate,
    input logic        cfg_valid,
    input logic        cfg_ready,
    input logic [2:0]  cfg_index,
    input logic [31:0] cfg_data
);

    `VRS_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(stretched_coordinate))
    `VRS_ASSERT_IMP(a_out_known, out_valid, !$isunknown(stretched_coordinate))
    `VRS_ASSERT_IMP(a_cfg_ready, cfg_valid, cfg_ready)
    `VRS_ASSERT_NXT(a_in_hold, in_valid && !in_ready, in_valid && $stable({coordinate, is_longitude}))

endmodule

bind variable_resolution_stretch_top vrs_checker u_vrs_checker (.*);

// File: tb/stretch_scoreboard.sv
// Scoreboard for the variable resolution stretch block: holds a copy of the
// config registers, predicts each mapped coordinate and checks results in order.
// Depends on vrs_pkg.
`timescale 1ns / 100ps

import vrs_pkg::*;

class stretch_scoreboard;
    cfg_t         regs;
    logic [31:0]  expected_coords[$];
    int           errors;
    int           checked;

    function void reset_regs();
        regs = '0;
        regs.inner_spacing = SPACING_ONE;
        regs.outer_spacing = SPACING_ONE;
        regs.stretch_ratio = R_ONE;
        expected_coords.delete();
        errors = 0;
        checked = 0;
    endfunction

    function void write_reg(reg_idx_t idx, logic [31:0] data);
        case (idx)
            REG_START_LON: regs.inner_start_lon = data;
            REG_END_LON:   regs.inner_end_lon = data;
            REG_START_LAT: regs.inner_start_lat = data;
            REG_END_LAT:   regs.inner_end_lat = data;
            REG_INNER_SP:  regs.inner_spacing = data[30:0];
            REG_OUTER_SP:  regs.outer_spacing = data[30:0];
            REG_RATIO:     regs.stretch_ratio = data;
            REG_HALF_CNT:  regs.half_stretched_count = data[9:0];
            default: ;
        endcase
    endfunction

    function longint clamp_sum(longint x);
        if (x > LIM)
            return LIM;
        if (x < -LIM)
            return -LIM;
        return x;
    endfunction

    function longint unsigned scale_by_ratio(longint unsigned x, longint unsigned r);
        longint unsigned y;
        y = (x * r + R_HALF) >> 30;
        return (y > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : y;
    endfunction

    function logic [31:0] finish_coord(longint p, bit lon);
        if (lon && p < WRAP_LO)
            p = clamp_sum(p + WRAP_ADD);
        if (p > OUT_MAX)
            p = OUT_MAX;
        if (p < OUT_MIN)
            p = OUT_MIN;
        return p[31:0];
    endfunction

    function logic [31:0] stretch_coord(logic signed [31:0] coord, bit lon);
        longint          c, p, acc, start, stop, addr, diff, sum, frac, tot, grown;
        longint unsigned span, di, dout, n_high, rem, n_st, p_rem, rim_frac;
        longint unsigned d, g, r, n_rim, mag, fmag, hc;
        c = coord;
        r = regs.stretch_ratio;
        if (r == R_ONE)
            return finish_coord(c, lon);
        start = lon ? longint'(regs.inner_start_lon) : longint'(regs.inner_start_lat);
        stop = lon ? longint'(regs.inner_end_lon) : longint'(regs.inner_end_lat);
        if (c >= start && c <= stop)
            return finish_coord(c, lon);
        span = (c < start) ? start - c : c - stop;
        di = (regs.inner_spacing == 0) ? 1 : regs.inner_spacing;
        dout = (regs.outer_spacing == 0) ? 1 : regs.outer_spacing;
        n_high = span / di;
        rem = span % di;
        hc = regs.half_stretched_count;
        if (hc > MAX_HALF_COUNT)
            hc = MAX_HALF_COUNT;
        if (n_high > hc)
        begin
            n_st = hc;
            p_rem = 0;
            rim_frac = rem;
        end
        else
        begin
            n_st = n_high;
            p_rem = rem;
            rim_frac = 0;
        end
        d = di;
        acc = 0;
        for (longint unsigned i = 0; i < n_st; i++)
        begin
            d = scale_by_ratio(d, r);
            acc += longint'(d) - longint'(di);
        end
        p = (c > start) ? c + acc : c - acc;
        g = R_ONE;
        for (longint unsigned i = 0; i < n_st + 1; i++)
            g = scale_by_ratio(g, r);
        grown = longint'((p_rem * g + R_HALF) >> 30);
        addr = grown - longint'(p_rem);
        p = (p > start) ? p + addr : p - addr;
        if (n_high > hc)
        begin
            n_rim = n_high - hc;
            diff = longint'(dout) - longint'(di);
            mag = (diff < 0) ? -diff : diff;
            if (mag != 0 && n_rim > longint'(LIM) / mag)
                sum = LIM;
            else
                sum = n_rim * mag;
            if (diff < 0)
                sum = -sum;
            fmag = (rim_frac * mag + FRAC_HALF) >> FRAC_BITS;
            frac = (diff < 0) ? -longint'(fmag) : longint'(fmag);
            tot = clamp_sum(sum + frac);
            p = (p > start) ? clamp_sum(p + tot) : clamp_sum(p - tot);
        end
        return finish_coord(p, lon);
    endfunction

    function void note_input(logic signed [31:0] coord, bit lon);
        expected_coords.push_back(stretch_coord(coord, lon));
    endfunction

    function void check_result(logic [31:0] got);
        logic [31:0] want;
        if (expected_coords.size() == 0)
        begin
            $display("%0t: unexpected result, expected none, actual %h", $time, got);
            errors++;
            return;
        end
        want = expected_coords.pop_front();
        checked++;
        if (got !== want)
        begin
            $display("%0t: stretched_coordinate mismatch, expected %h, actual %h",
                     $time, want, got);
            errors++;
        end
    endfunction
endclass

// File: tb/testbench.sv
// Top of the variable resolution stretch testbench: clock, reset, drivers,
// monitors, directed and random config phases. Depends on vrs_pkg and
// stretch_scoreboard.
`timescale 1ns / 100ps

module testbench;
    import vrs_pkg::*;

    localparam int CYCLE_LIMIT = 12000000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic signed [31:0] coordinate = '0;
    logic               is_longitude = 1'b0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [31:0] stretched_coordinate;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [2:0]         cfg_index = '0;
    logic [31:0]        cfg_data = '0;

    stretch_scoreboard sb = new();
    int                cycles = 0;
    int                items_sent = 0;
    int                phases_run = 0;

    variable_resolution_stretch_top dut (.*);

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d results outstanding", $time, sb.expected_coords.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            sb.note_input(coordinate, is_longitude);
        if (rst_n && cfg_valid && cfg_ready)
            sb.write_reg(reg_idx_t'(cfg_index), cfg_data);
        if (rst_n && out_valid && out_ready)
            sb.check_result(stretched_coordinate);
    end

    // receiver stalls: mostly short, a few long, with stall-free stretches
    int stall_left = 0;
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_ready <= 1'b0;
        end
        else if ($urandom_range(0, 99) < 15 && (cycles / 3000) % 4 != 3)
        begin
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                      : $urandom_range(0, 3);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    function automatic int pick_gap();
        if ((items_sent / 100) % 5 == 4)
            return 0;
        if ($urandom_range(0, 9) < 7)
            return 0;
        return ($urandom_range(0, 9) == 0) ? $urandom_range(20, 90) : $urandom_range(1, 4);
    endfunction

    task automatic send_coord(logic signed [31:0] c, bit lon);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        coordinate <= c;
        is_longitude <= lon;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_coords.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic load_config(cfg_t c);
        wait_idle();
        write_reg(REG_START_LON, c.inner_start_lon);
        write_reg(REG_END_LON, c.inner_end_lon);
        write_reg(REG_START_LAT, c.inner_start_lat);
        write_reg(REG_END_LAT, c.inner_end_lat);
        write_reg(REG_INNER_SP, {1'b0, c.inner_spacing});
        write_reg(REG_OUTER_SP, {1'b0, c.outer_spacing});
        write_reg(REG_RATIO, c.stretch_ratio);
        write_reg(REG_HALF_CNT, {22'd0, c.half_stretched_count});
        cfg_valid <= 1'b0;
        @(posedge clk);
        phases_run++;
    endtask

    function automatic logic [31:0] deg(int d);
        return d <<< FRAC_BITS;
    endfunction

    function automatic cfg_t random_config();
        cfg_t c;
        logic signed [31:0] a, b;
        a = $urandom_range(0, 7) == 0 ? $urandom() : $signed($urandom_range(0, 400)) <<< 20;
        b = a + ($urandom_range(0, 7) == 0 ? $urandom() : $urandom_range(0, 60 << 20));
        c.inner_start_lon = a;
        c.inner_end_lon = b;
        a = $urandom_range(0, 7) == 0 ? $urandom() : $signed(-$urandom_range(0, 90)) <<< 20;
        b = a + ($urandom_range(0, 7) == 0 ? $urandom() : $urandom_range(0, 60 << 20));
        c.inner_start_lat = a;
        c.inner_end_lat = b;
        c.inner_spacing = $urandom_range(0, 5) == 0 ? 31'($urandom())
                                                    : 31'($urandom_range(1, 1 << 22));
        c.outer_spacing = $urandom_range(0, 5) == 0 ? 31'($urandom())
                                                    : 31'($urandom_range(0, 1 << 23));
        case ($urandom_range(0, 7))
            0: c.stretch_ratio = R_ONE;
            1: c.stretch_ratio = $urandom();
            2: c.stretch_ratio = R_ONE - $urandom_range(1, 1 << 26);
            default: c.stretch_ratio = R_ONE + $urandom_range(1, 1 << 26);
        endcase
        c.half_stretched_count = $urandom_range(0, 9) == 0 ? 10'($urandom_range(0, 1023))
                                                           : 10'($urandom_range(0, 16));
        return c;
    endfunction

    task automatic random_coords(cfg_t c, int count);
        logic signed [31:0] base, step, v;
        bit lon;
        for (int i = 0; i < count; i++)
        begin
            lon = 1'($urandom_range(0, 1));
            step = (c.inner_spacing == 0) ? 1 : c.inner_spacing;
            if ($urandom_range(0, 9) < 3)
                v = $urandom();
            else
            begin
                if (lon)
                    base = $urandom_range(0, 1) ? c.inner_start_lon : c.inner_end_lon;
                else
                    base = $urandom_range(0, 1) ? c.inner_start_lat : c.inner_end_lat;
                v = base + $signed($urandom_range(0, (c.half_stretched_count + 6) * 2))
                    * step - (c.half_stretched_count + 6) * step
                    + $signed($urandom_range(0, step - 1));
            end
            send_coord(v, lon);
        end
    endtask

    initial
    begin
        cfg_t c;
        int n;
        sb.reset_regs();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // uniform grid at reset defaults: wrap only
        send_coord(32'sh8000_0000, 1'b1);
        send_coord(32'sh7FFF_FFFF, 1'b1);
        send_coord(deg(179), 1'b1);
        send_coord(deg(-10), 1'b0);

        // a typical box with stretching
        c.inner_start_lon = deg(10);
        c.inner_end_lon = deg(20);
        c.inner_start_lat = deg(-5);
        c.inner_end_lat = deg(5);
        c.inner_spacing = 31'h0008_0000;
        c.outer_spacing = 31'h0020_0000;
        c.stretch_ratio = R_ONE + 32'h0333_3333;
        c.half_stretched_count = 10'd4;
        load_config(c);
        send_coord(deg(15), 1'b1);
        send_coord(deg(10), 1'b1);
        send_coord(deg(20), 1'b1);
        send_coord(deg(8) + 32'sh0003_0000, 1'b1);
        send_coord(deg(23), 1'b1);
        send_coord(deg(-9), 1'b0);
        send_coord(deg(40), 1'b0);
        send_coord(32'sh8000_0000, 1'b0);
        send_coord(32'sh7FFF_FFFF, 1'b0);
        send_coord(32'sh7FFF_FFFF, 1'b1);

        // zero spacings, inverted box, ratio zero
        c.inner_start_lat = deg(5);
        c.inner_end_lat = deg(-5);
        c.inner_spacing = '0;
        c.outer_spacing = '0;
        c.stretch_ratio = '0;
        load_config(c);
        send_coord(deg(0), 1'b0);
        send_coord(deg(7), 1'b0);
        send_coord(deg(-300), 1'b1);

        // full count, largest ratio, widest spacings
        c.inner_spacing = 31'h7FFF_FFFF;
        c.outer_spacing = 31'h0000_0001;
        c.stretch_ratio = 32'hFFFF_FFFF;
        c.half_stretched_count = 10'd1023;
        load_config(c);
        send_coord(32'sh8000_0000, 1'b0);
        send_coord(32'sh7FFF_FFFF, 1'b1);
        c.inner_spacing = 31'h0000_1000;
        c.outer_spacing = 31'h7FFF_FFFF;
        c.stretch_ratio = R_ONE + 32'h0000_4000;
        load_config(c);
        send_coord(32'sh8000_0000, 1'b0);
        send_coord(32'sh7FFF_FFFF, 1'b1);
        send_coord(deg(30), 1'b0);

        while (items_sent < 1480)
        begin
            c = random_config();
            load_config(c);
            n = (c.half_stretched_count > 64) ? 20 : 200;
            random_coords(c, n / 2);
            wait_idle();
            random_coords(c, n - n / 2);
        end

        wait_idle();
        repeat (50) @(posedge clk);
        $display("Covered %0d coordinates over %0d register settings, %0d results checked.",
                 items_sent, phases_run, sb.checked);
        if (sb.errors == 0 && sb.expected_coords.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

// File: sim.f
+incdir+design
design/vrs_pkg.sv
design/vrs_front.sv
design/vrs_queue.sv
design/vrs_back.sv
design/variable_resolution_stretch_top.sv
design/vrs_checker.sv
tb/stretch_scoreboard.sv
tb/testbench.sv
